@@ hdl/swpd_pkg.sv @@
// ----------------------------------------------------------------------------
// swpd_pkg
// Shared types, constants and table functions for the sine wave pixel
// displacer: register map, size limits, mod-360 reciprocals, sine ROM entry.
// ----------------------------------------------------------------------------
package swpd_pkg;

  localparam int unsigned DIM_W      = 13;
  localparam int unsigned MAX_DIM    = 4096;
  localparam int unsigned REG_ADDR_W = 5;
  localparam int unsigned ROM_DEPTH  = 91;
  localparam int unsigned STEP_DEPTH = 128;

  // floor(x / 360) by reciprocal, exact over the stated input ranges
  localparam int unsigned MOD12_K     = 2913;   // x < 4096
  localparam int unsigned MOD12_SHIFT = 20;
  localparam int unsigned MOD16_K     = 46604;  // x < 65536
  localparam int unsigned MOD16_SHIFT = 24;

  localparam int unsigned SINE_Q        = 30;
  localparam logic [63:0] PI_Q30        = 64'd3373259426;
  localparam int unsigned TAYLOR_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

  typedef enum logic [2:0] {
    REG_DIRECTION,
    REG_EDGE_MODE,
    REG_AMPLITUDE,
    REG_WAVELENGTH,
    REG_WIDTH,
    REG_HEIGHT,
    REG_DEPTH
  } reg_index_t;

  // Quarter-wave sine entry for a whole degree 0..90, rom_bits fraction bits.
  function automatic logic [63:0] sine_entry(input int unsigned deg,
                                             input int unsigned rom_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    logic [63:0] res;
    x    = (64'(deg) * PI_Q30 + 64'd90) / 64'd180;
    x2   = (x * x) >> SINE_Q;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = (term * x2) >> SINE_Q;
      term = term / 64'(TAYLOR_DIV[k-1]);
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (deg == 90) begin
      res = 64'd1 << rom_bits;
    end else begin
      res = (64'(sum) + (64'd1 << (SINE_Q - rom_bits - 1))) >> (SINE_Q - rom_bits);
    end
    return res;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ hdl/sine_wave_pixel_displacer_core.sv @@
// ----------------------------------------------------------------------------
// sine_wave_pixel_displacer_core
// Moves each source pixel onto a sine wave: destination coordinates from a
// sine ROM offset, in extend or hold-and-wrap edge mode. APB config port.
// ----------------------------------------------------------------------------
// One request per clock, every clock: busy stays low and the nine-stage
// pipeline (two mod-360 reductions, quadrant fold, sine ROM, amplitude
// multiply, edge handling) returns each result on a one-cycle done strobe in
// request order. The receiver cannot stall the strobe. Configuration may be
// written only with no request in flight; register i sits at byte address
// 4*i.
module sine_wave_pixel_displacer_core import swpd_pkg::*; #(
  parameter int unsigned SINE_ROM_BITS = 18
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [11:0]           src_x,
  input  logic [11:0]           src_y,
  input  logic [23:0]           pixel_in,
  input  logic                  last_in,
  output logic                  done,
  output logic [12:0]           dest_x,
  output logic [12:0]           dest_y,
  output logic [23:0]           pixel_out,
  output logic                  out_of_range,
  output logic                  last_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned STAGES = 9;
  localparam int unsigned ROM_W  = SINE_ROM_BITS + 1;
  localparam int unsigned PROD_W = ROM_W + 8;

  typedef struct packed {
    logic [11:0] sx;
    logic [11:0] sy;
    logic [23:0] pix;
    logic        last;
  } item_t;

  // configuration
  logic             direction;
  logic             edge_mode;
  logic [7:0]       amplitude;
  logic [6:0]       wavelength;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic             pixel_depth;
  logic [7:0]       wave_step;
  logic [DIM_W-1:0] size_w;
  logic [DIM_W-1:0] size_h;
  logic             cfg_wr;

  // constant tables
  logic [ROM_W-1:0] sine_rom [ROM_DEPTH];
  logic [7:0]       step_tab [STEP_DEPTH];

  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    localparam logic [63:0] ENTRY = sine_entry(g, SINE_ROM_BITS);
    assign sine_rom[g] = ROM_W'(ENTRY);
  end

  for (genvar g = 0; g < STEP_DEPTH; g++) begin : g_step
    localparam int unsigned STEP = 180 / ((g == 0) ? 1 : g);
    assign step_tab[g] = 8'(STEP);
  end

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction    <= 1'b0;
      edge_mode    <= 1'b0;
      amplitude    <= '0;
      wavelength   <= 7'd1;
      image_width  <= DIM_W'(1);
      image_height <= DIM_W'(1);
      pixel_depth  <= 1'b0;
      wave_step    <= 8'd180;
      size_w       <= DIM_W'(1);
      size_h       <= DIM_W'(1);
    end else if (cfg_wr) begin
      case (reg_index_t'(paddr[4:2]))
        REG_DIRECTION:  direction <= pwdata[0];
        REG_EDGE_MODE:  edge_mode <= pwdata[0];
        REG_AMPLITUDE:  amplitude <= pwdata[7:0];
        REG_WAVELENGTH: begin
          wavelength <= pwdata[6:0];
          wave_step  <= step_tab[pwdata[6:0]];
        end
        REG_WIDTH: begin
          image_width <= pwdata[DIM_W-1:0];
          size_w      <= clamp_dim(pwdata[DIM_W-1:0]);
        end
        REG_HEIGHT: begin
          image_height <= pwdata[DIM_W-1:0];
          size_h       <= clamp_dim(pwdata[DIM_W-1:0]);
        end
        REG_DEPTH:      pixel_depth <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[4:2]))
      REG_DIRECTION:  prdata = 32'(direction);
      REG_EDGE_MODE:  prdata = 32'(edge_mode);
      REG_AMPLITUDE:  prdata = 32'(amplitude);
      REG_WAVELENGTH: prdata = 32'(wavelength);
      REG_WIDTH:      prdata = 32'(image_width);
      REG_HEIGHT:     prdata = 32'(image_height);
      REG_DEPTH:      prdata = 32'(pixel_depth);
      default:        prdata = '0;
    endcase
  end

  // pipeline
  logic [STAGES-1:1] vld;
  item_t             item_q [1:STAGES-1];

  logic [11:0]        idx1;
  logic [3:0]         q1;
  logic [8:0]         r2;
  logic [15:0]        p3;
  logic [15:0]        p4;
  logic [7:0]         q4;
  logic [6:0]         deg5;
  logic               neg5;
  logic [ROM_W-1:0]   rom6;
  logic               neg6;
  logic signed [8:0]  off7;
  logic signed [14:0] t8;
  logic signed [14:0] tp8;
  logic signed [14:0] tm8;
  logic               lo8;
  logic               hi8;
  logic [12:0]        ext8;

  logic [11:0]        idx_in;
  logic [8:0]         ang5;
  logic [6:0]         deg_c;
  logic               neg_c;
  logic [PROD_W-1:0]  prod7;
  logic [7:0]         mag7;
  logic [11:0]        coord8;
  logic [DIM_W-1:0]   size8;
  logic signed [14:0] t_c;
  logic signed [14:0] sz_c;
  logic signed [14:0] tf9;
  logic               oor9;
  logic [12:0]        shifted9;

  assign idx_in = direction ? src_y : src_x;
  assign ang5   = 9'(p4 - 16'(q4) * 16'd360);

  always_comb begin
    if (ang5 inside {[0:90]}) begin
      deg_c = 7'(ang5);
      neg_c = 1'b0;
    end else if (ang5 inside {[91:180]}) begin
      deg_c = 7'(9'd180 - ang5);
      neg_c = 1'b0;
    end else if (ang5 inside {[181:270]}) begin
      deg_c = 7'(ang5 - 9'd180);
      neg_c = 1'b1;
    end else begin
      deg_c = 7'(9'd360 - ang5);
      neg_c = 1'b1;
    end
  end

  assign prod7  = PROD_W'(amplitude) * PROD_W'(rom6);
  assign mag7   = 8'(prod7 >> SINE_ROM_BITS);
  assign coord8 = direction ? item_q[7].sx : item_q[7].sy;
  assign size8  = direction ? size_w : size_h;
  assign sz_c   = $signed({2'b00, size8});
  assign t_c    = $signed({3'b000, coord8}) + $signed({{6{off7[8]}}, off7});

  always_comb begin
    if (lo8) begin
      tf9 = tp8;
    end else if (hi8) begin
      tf9 = tm8;
    end else begin
      tf9 = t8;
    end
    oor9 = edge_mode && ((tf9 < 0) || (tf9 >= $signed({2'b00, size8})));
    if (!edge_mode) begin
      shifted9 = ext8;
    end else if (oor9) begin
      shifted9 = '0;
    end else begin
      shifted9 = tf9[12:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[STAGES-2:1], start & ~busy};
      done <= vld[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    item_q[1] <= '{sx: src_x, sy: src_y, pix: pixel_in, last: last_in};
    for (int s = 2; s < STAGES; s++) begin
      item_q[s] <= item_q[s-1];
    end
    idx1 <= idx_in;
    q1   <= 4'((24'(idx_in) * 24'(MOD12_K)) >> MOD12_SHIFT);
    r2   <= 9'(idx1 - 12'(q1) * 12'd360);
    p3   <= 16'(r2) * 16'(wave_step);
    p4   <= p3;
    q4   <= 8'((32'(p3) * 32'(MOD16_K)) >> MOD16_SHIFT);
    deg5 <= deg_c;
    neg5 <= neg_c;
    rom6 <= sine_rom[deg5];
    neg6 <= neg5;
    off7 <= neg6 ? -$signed({1'b0, mag7}) : $signed({1'b0, mag7});
    t8   <= t_c;
    tp8  <= t_c + sz_c;
    tm8  <= t_c - sz_c;
    lo8  <= t_c < 0;
    hi8  <= t_c >= sz_c;
    ext8 <= 13'(t_c + $signed({7'b0, amplitude}));
    dest_x       <= direction ? shifted9 : {1'b0, item_q[8].sx};
    dest_y       <= direction ? {1'b0, item_q[8].sy} : shifted9;
    pixel_out    <= pixel_depth ? item_q[8].pix : {16'b0, item_q[8].pix[7:0]};
    out_of_range <= oor9;
    last_out     <= item_q[8].last;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##STAGES done)
    else $error("request did not complete after pipeline latency");

  a_oor_hold: assert property (@(posedge clk) disable iff (rst)
    (done && out_of_range) |-> edge_mode)
    else $error("out_of_range raised in extend mode");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (done && out_of_range) |-> (direction ? (dest_x == '0) : (dest_y == '0)))
    else $error("out_of_range result with nonzero shifted coordinate");

  a_hold_in: assert property (@(posedge clk) disable iff (rst)
    (done && edge_mode && !out_of_range) |->
      (direction ? (dest_x < size_w) : (dest_y < size_h)))
    else $error("wrapped coordinate outside image without flag");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    (done && !pixel_depth) |-> (pixel_out[23:8] == '0))
    else $error("eight-bit pixel with upper bytes set");

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Sine wave pixel displacer testbench
// Sends pixels through the start/busy port and rewrites the configuration over
// APB between phases. A scoreboard predicts each destination from its own
// quarter-wave sine table and checks every done strobe in request order. A
// directed set covers the field extremes, wrap and out-of-range cases and
// clamped sizes. Randomized configurations and pixels follow, under three
// sender idle profiles.
// ----------------------------------------------------------------------------
module testbench;
  import swpd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SINE_FRAC = 18;
  localparam int unsigned FIX_Q     = 30;
  localparam logic [63:0] PI_FIX    = 64'd3373259426;

  typedef struct {
    logic [12:0] dx;
    logic [12:0] dy;
    logic [23:0] pix;
    logic        oor;
    logic        last;
  } placement_t;

  class wave_placement_check;
    logic [63:0]  quarter_sine [0:90];
    bit           dir_horiz;
    bit           hold_mode;
    int unsigned  amp;
    int unsigned  wl_set;
    int unsigned  width_set;
    int unsigned  height_set;
    bit           rgb;
    placement_t   due_placements [$];
    int unsigned  mismatches;

    function new();
      logic [63:0] rad;
      logic [63:0] rad_sq;
      logic [63:0] tm;
      longint      acc;
      for (int d = 0; d <= 90; d++) begin
        rad    = (64'(d) * PI_FIX + 64'd90) / 64'd180;
        rad_sq = (rad * rad) >> FIX_Q;
        tm     = rad;
        acc    = longint'(rad);
        for (int k = 1; k <= 8; k++) begin
          tm = (tm * rad_sq) >> FIX_Q;
          tm = tm / 64'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) begin
            acc = acc - longint'(tm);
          end else begin
            acc = acc + longint'(tm);
          end
        end
        if (acc < 0) begin
          acc = 0;
        end
        if (d == 90) begin
          quarter_sine[d] = 64'd1 << SINE_FRAC;
        end else begin
          quarter_sine[d] = (64'(acc) + (64'd1 << (FIX_Q - SINE_FRAC - 1)))
                            >> (FIX_Q - SINE_FRAC);
        end
      end
      dir_horiz  = 1'b0;
      hold_mode  = 1'b0;
      amp        = 0;
      wl_set     = 1;
      width_set  = 1;
      height_set = 1;
      rgb        = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [31:0] val);
      case (idx)
        REG_DIRECTION:  dir_horiz  = val[0];
        REG_EDGE_MODE:  hold_mode  = val[0];
        REG_AMPLITUDE:  amp        = 32'(val[7:0]);
        REG_WAVELENGTH: wl_set     = 32'(val[6:0]);
        REG_WIDTH:      width_set  = 32'(val[12:0]);
        REG_HEIGHT:     height_set = 32'(val[12:0]);
        REG_DEPTH:      rgb        = val[0];
        default: ;
      endcase
    endfunction

    // size along the displaced axis, clamped to 1..MAX_DIM
    function int unsigned wrap_size();
      int unsigned sz;
      sz = dir_horiz ? width_set : height_set;
      if (sz == 0) begin
        sz = 1;
      end else if (sz > MAX_DIM) begin
        sz = MAX_DIM;
      end
      return sz;
    endfunction

    function void note_pixel(logic [11:0] sx, logic [11:0] sy, logic [23:0] pin,
                             logic lin);
      placement_t  p;
      int unsigned idx;
      int unsigned crd;
      int unsigned sz;
      int unsigned step;
      int unsigned ang;
      int unsigned q;
      logic [63:0] mag;
      int          off;
      int          t;
      int          shifted;
      bit          oor;
      idx  = dir_horiz ? 32'(sy) : 32'(sx);
      crd  = dir_horiz ? 32'(sx) : 32'(sy);
      sz   = wrap_size();
      step = 180 / ((wl_set == 0) ? 1 : wl_set);
      ang  = (idx * step) % 360;
      if (ang <= 90) begin
        q = ang;
      end else if (ang <= 180) begin
        q = 180 - ang;
      end else if (ang <= 270) begin
        q = ang - 180;
      end else begin
        q = 360 - ang;
      end
      mag = (64'(amp) * quarter_sine[q]) >> SINE_FRAC;
      off = (ang > 180) ? -int'(mag) : int'(mag);
      oor = 1'b0;
      if (!hold_mode) begin
        shifted = int'(crd) + int'(amp) + off;
      end else begin
        t = int'(crd) + off;
        if (t < 0) begin
          t = t + int'(sz);
        end else if (t > int'(sz) - 1) begin
          t = t - int'(sz);
        end
        if (t < 0 || t >= int'(sz)) begin
          oor     = 1'b1;
          shifted = 0;
        end else begin
          shifted = t;
        end
      end
      p.dx   = dir_horiz ? 13'(shifted) : 13'(sx);
      p.dy   = dir_horiz ? 13'(sy) : 13'(shifted);
      p.pix  = rgb ? pin : {16'h0, pin[7:0]};
      p.oor  = oor;
      p.last = lin;
      due_placements.push_back(p);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field,
                 want, got);
      end
    endfunction

    function void check_placement(logic [12:0] dx, logic [12:0] dy,
                                  logic [23:0] pix, logic oor, logic last);
      placement_t p;
      if (due_placements.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request pending, expected none, actual dx=%0d dy=%0d",
                 $time, dx, dy);
      end else begin
        p = due_placements.pop_front();
        compare_field("dest_x", 32'(p.dx), 32'(dx));
        compare_field("dest_y", 32'(p.dy), 32'(dy));
        compare_field("pixel_out", 32'(p.pix), 32'(pix));
        compare_field("out_of_range", 32'(p.oor), 32'(oor));
        compare_field("last_out", 32'(p.last), 32'(last));
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [11:0]           src_x = '0;
  logic [11:0]           src_y = '0;
  logic [23:0]           pixel_in = '0;
  logic                  last_in = 1'b0;
  logic                  done;
  logic [12:0]           dest_x;
  logic [12:0]           dest_y;
  logic [23:0]           pixel_out;
  logic                  out_of_range;
  logic                  last_out;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [REG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  wave_placement_check sb;
  int unsigned         idle_pct = 0;

  sine_wave_pixel_displacer_core #(.SINE_ROM_BITS(SINE_FRAC)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .src_x(src_x), .src_y(src_y), .pixel_in(pixel_in), .last_in(last_in),
    .done(done), .dest_x(dest_x), .dest_y(dest_y), .pixel_out(pixel_out),
    .out_of_range(out_of_range), .last_out(last_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        sb.note_pixel(src_x, src_y, pixel_in, last_in);
      end
      if (done) begin
        sb.check_placement(dest_x, dest_y, pixel_out, out_of_range, last_out);
      end
    end
  end

  // psel is left high; the caller closes the transfer sequence
  task automatic reg_write(reg_index_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(bit dir, bit hold, int unsigned a, int unsigned wl,
                            int unsigned w, int unsigned h, bit depth);
    reg_write(REG_DIRECTION, 32'(dir));
    reg_write(REG_EDGE_MODE, 32'(hold));
    reg_write(REG_AMPLITUDE, 32'(a));
    reg_write(REG_WAVELENGTH, 32'(wl));
    reg_write(REG_WIDTH, 32'(w));
    reg_write(REG_HEIGHT, 32'(h));
    reg_write(REG_DEPTH, 32'(depth));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // start stays high between back-to-back requests
  task automatic send_request(logic [11:0] sx, logic [11:0] sy, logic [23:0] pix,
                              logic lst);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    src_x    <= sx;
    src_y    <= sy;
    pixel_in <= pix;
    last_in  <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.due_placements.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic int unsigned pick_dim();
    int unsigned v;
    case ($urandom_range(7))
      0: v = 0;
      1: v = 1;
      2: v = MAX_DIM;
      3: v = 8191;
      4: v = $urandom_range(8191);
      default: v = $urandom_range(300, 1);
    endcase
    return v;
  endfunction

  task automatic random_config();
    int unsigned a;
    int unsigned wl;
    case ($urandom_range(3))
      0: a = 0;
      1: a = 255;
      default: a = $urandom_range(255);
    endcase
    case ($urandom_range(5))
      0: wl = 0;
      1: wl = 1;
      2: wl = 127;
      3: wl = 100;
      default: wl = $urandom_range(100, 1);
    endcase
    set_config(1'($urandom_range(1)), 1'($urandom_range(1)), a, wl, pick_dim(),
               pick_dim(), 1'($urandom_range(1)));
  endtask

  task automatic send_random_pixel();
    int unsigned lim;
    logic [11:0] crd;
    logic [11:0] idx;
    lim = sb.wrap_size();
    crd = ($urandom_range(9) < 8) ? 12'($urandom_range(lim - 1)) : 12'($urandom);
    idx = 12'($urandom);
    if (sb.dir_horiz) begin
      send_request(crd, idx, 24'($urandom), $urandom_range(15) == 0);
    end else begin
      send_request(idx, crd, 24'($urandom), $urandom_range(15) == 0);
    end
  endtask

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned profile [3];
    int unsigned settle;
    profile = '{14, 50, 0};
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extend mode, quarter-turn steps: peaks of both signs, field extremes
    set_config(1'b0, 1'b0, 255, 2, MAX_DIM, MAX_DIM, 1'b1);
    send_request(12'd0, 12'd0, 24'hFFFFFF, 1'b1);
    send_request(12'd1, 12'd4095, 24'h000000, 1'b0);
    send_request(12'd3, 12'd0, 24'hA5A5A5, 1'b0);
    send_request(12'd2, 12'd17, 24'h5A5A5A, 1'b0);
    send_request(12'd4095, 12'd4095, 24'h123456, 1'b1);
    wait_drained();

    // hold mode: wrap past both edges, source beyond the image
    set_config(1'b1, 1'b1, 60, 2, 100, 1, 1'b0);
    send_request(12'd50, 12'd1, 24'hFFFFFF, 1'b0);
    send_request(12'd10, 12'd3, 24'h00FF00, 1'b0);
    send_request(12'd99, 12'd0, 24'h0000FF, 1'b0);
    send_request(12'd4095, 12'd2, 24'hFF0000, 1'b0);
    send_request(12'd0, 12'd4095, 24'h808080, 1'b1);
    wait_drained();

    // zero size clamps to one; single fold leaves the pixel outside
    set_config(1'b1, 1'b1, 255, 2, 0, 0, 1'b1);
    send_request(12'd0, 12'd1, 24'h000001, 1'b0);
    send_request(12'd0, 12'd3, 24'h800000, 1'b0);
    send_request(12'd0, 12'd0, 24'hFFFFFF, 1'b1);
    wait_drained();

    // one-degree step, oversized height clamps to the maximum
    set_config(1'b0, 1'b1, 255, 127, 8191, 8191, 1'b0);
    send_request(12'd90, 12'd4095, 24'hFFFFFF, 1'b0);
    send_request(12'd270, 12'd100, 24'hFEDCBA, 1'b0);
    send_request(12'd45, 12'd4000, 24'h13579B, 1'b0);
    send_request(12'd4095, 12'd10, 24'h2468AC, 1'b1);
    wait_drained();

    // zero wavelength, zero amplitude
    set_config(1'b0, 1'b0, 0, 0, 1, 1, 1'b0);
    send_request(12'd4095, 12'd4095, 24'hFFFFFF, 1'b1);
    send_request(12'd7, 12'd9, 24'h0F0F0F, 1'b0);
    wait_drained();

    foreach (profile[p]) begin
      idle_pct = profile[p];
      repeat (4) begin
        random_config();
        repeat (167) send_random_pixel();
        wait_drained();
      end
    end

    settle = 0;
    while (sb.due_placements.size() != 0 && settle < 1000) begin
      @(posedge clk);
      settle++;
    end
    repeat (12) @(posedge clk);
    if (sb.due_placements.size() != 0) begin
      $display("%0t: %0d results never arrived, expected 0 pending, actual %0d",
               $time, sb.due_placements.size(), sb.due_placements.size());
    end
    if (sb.mismatches == 0 && sb.due_placements.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
